FILE: rtl/tgrc_pkg.sv
// Shared types and constants of the tile grid rectangle collision block.
// No dependencies; imported by every module of the block.
`default_nettype none

package tgrc_pkg;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int POS_W     = 12;
    localparam int SIZE_W    = 12;
    localparam int GRID_W    = 7;
    localparam int CFG_IDX_W = 1;

    // Pixel coordinate after adding a size, also wide enough for any cell quotient
    localparam int CRD_W = POS_W + 1;

    // Reciprocal multiply for division by a cell size of up to 256 pixels:
    // q = (x * ceil(2^DIV_SHIFT / size)) >> DIV_SHIFT is exact for x < 2^CRD_W.
    localparam int DIV_SHIFT  = CRD_W + 8;
    localparam int RECIP_BITS = DIV_SHIFT + 1;
    localparam int PROD_W     = CRD_W + RECIP_BITS;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

    // Constant operand of the shared multiplier
    typedef enum logic [2:0] {
        MSEL_RECIP_X = 3'd0,
        MSEL_RECIP_Y = 3'd1,
        MSEL_CELL_X  = 3'd2,
        MSEL_CELL_Y  = 3'd3,
        MSEL_COLS    = 3'd4
    } t_msel;

    typedef struct packed {
        t_msel            sel;
        logic [CRD_W-1:0] operand;
    } t_mul_req;

endpackage

`default_nettype wire

FILE: rtl/tile_grid_rect_collision.sv
// Top level: tile grid occupancy map with cell write/read and rectangle collision query.
// Depends on tgrc_pkg and tgrc_mul.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_kind, i_pos_x, i_pos_y, i_occupied,
//           |           |                            | i_rect_width, i_rect_height
//   out     | output    | o_out_valid / i_out_ready  | o_cell_value, o_hit
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One transaction in flight. After acceptance a write passes through S_ACC and S_MEM, a
// read also through S_RDATA, and a query runs its setup on the shared multiplier, then
// reads one covered cell per cycle (the single map read port); a hit ends the walk early.
// Reset (synchronous, active low) starts a clearing pass over all MAX_COLS*MAX_ROWS
// cells of the map; o_in_ready stays low during it, configuration writes are taken always.
// The result register lets the next transaction enter while a result waits; a new
// result waits in the done state while the output register is still full.
`default_nettype none

module tile_grid_rect_collision #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    parameter int CELL_W   = 16,
    parameter int CELL_H   = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // item channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [tgrc_pkg::KIND_W-1:0]      i_kind,
    input  wire logic [tgrc_pkg::POS_W-1:0]       i_pos_x,
    input  wire logic [tgrc_pkg::POS_W-1:0]       i_pos_y,
    input  wire logic                             i_occupied,
    input  wire logic [tgrc_pkg::SIZE_W-1:0]      i_rect_width,
    input  wire logic [tgrc_pkg::SIZE_W-1:0]      i_rect_height,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_cell_value,
    output logic                                  o_hit,
    // configuration channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tgrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tgrc_pkg::GRID_W-1:0]      i_cfg_data
);
    import tgrc_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CRD_W-1:0] LP_COLS     = CRD_W'(MAX_COLS);
    localparam logic [CRD_W-1:0] LP_ROWS     = CRD_W'(MAX_ROWS);
    localparam logic [AW-1:0]    LP_ROW_STEP = AW'(MAX_COLS);
    localparam logic [AW-1:0]    LP_LAST     = AW'(DEPTH - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ACC   = 8'b0000_0010,  // cell access: bounds check, row*cols multiply
        S_MEM   = 8'b0000_0100,  // cell access: map write or read
        S_RDATA = 8'b0000_1000,  // read data back
        S_DIV   = 8'b0001_0000,  // query setup on the shared multiplier
        S_WALK  = 8'b0010_0000,  // one covered cell per cycle
        S_DRAIN = 8'b0100_0000,  // check of the last cell read
        S_DONE  = 8'b1000_0000   // result waits for the output register
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [GRID_W-1:0] r_grid_w, r_grid_h;
    logic [CRD_W-1:0]  w_nc, w_nr;

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // transaction payload
    logic [KIND_W-1:0] r_kind;
    logic [POS_W-1:0]  r_px, r_py;
    logic              r_occ;
    logic [CRD_W-1:0]  r_qx, r_qy, r_qr, r_qb;

    // query setup and walk
    logic [2:0]       r_step;
    logic [CRD_W-1:0] r_c0, r_c1, r_r0, r_r1, r_c1_raw, r_r1_raw;
    logic             r_col_bad, r_row_bad;
    logic [CRD_W-1:0] r_col, r_row;
    logic [AW-1:0]    r_addr, r_col_base;
    logic             r_chk_valid, r_chk_pass;
    logic             w_hit_now, w_empty, w_last_row, w_last_col;
    logic [CRD_W-1:0] w_quot;

    // results
    logic r_inside, r_res_cell, r_res_hit;
    logic r_out_valid, r_out_cell, r_out_hit;
    logic w_out_room;

    // shared multiplier
    t_mul_req          w_mul_req;
    logic [PROD_W-1:0] w_prod;

    // occupancy map
    logic          r_map [DEPTH];
    logic          r_map_q;
    logic          w_map_we, w_map_re, w_map_wd;
    logic [AW-1:0] w_map_addr, w_cell_addr;

    tgrc_mul #(
        .CELL_W   (CELL_W),
        .CELL_H   (CELL_H),
        .MAX_COLS (MAX_COLS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    // grid in use, clipped to the storage size
    assign w_nc = (CRD_W'(r_grid_w) < LP_COLS) ? CRD_W'(r_grid_w) : LP_COLS;
    assign w_nr = (CRD_W'(r_grid_h) < LP_ROWS) ? CRD_W'(r_grid_h) : LP_ROWS;

    assign w_quot      = w_prod[DIV_SHIFT +: CRD_W];
    assign w_cell_addr = w_prod[AW-1:0] + AW'(r_px);
    assign w_hit_now   = r_chk_valid && r_map_q && r_chk_pass;
    assign w_empty     = (w_nc == '0) || (w_nr == '0) || (r_c0 > r_c1) || (r_r0 > r_r1);
    assign w_last_row  = (r_row == r_r1);
    assign w_last_col  = (r_col == r_c1);
    assign w_out_room  = !r_out_valid || i_out_ready;

    assign o_in_ready   = (r_state == S_IDLE) && !r_clr_busy;
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_cell;
    assign o_hit        = r_out_hit;

    // multiplier schedule: the product of the operand issued at step k is seen at step k+1
    always_comb begin
        w_mul_req.sel     = MSEL_RECIP_X;
        w_mul_req.operand = r_qx;
        case (r_state)
            S_ACC: begin
                w_mul_req.sel     = MSEL_COLS;
                w_mul_req.operand = CRD_W'(r_py);
            end
            S_DIV: begin
                case (r_step)
                    3'd0: begin
                        w_mul_req.sel     = MSEL_RECIP_X;
                        w_mul_req.operand = r_qx;
                    end
                    3'd1: begin
                        w_mul_req.sel     = MSEL_RECIP_X;
                        w_mul_req.operand = r_qr;
                    end
                    3'd2: begin
                        w_mul_req.sel     = MSEL_RECIP_Y;
                        w_mul_req.operand = r_qy;
                    end
                    3'd3: begin
                        w_mul_req.sel     = MSEL_RECIP_Y;
                        w_mul_req.operand = r_qb;
                    end
                    3'd4: begin
                        w_mul_req.sel     = MSEL_CELL_X;
                        w_mul_req.operand = r_c1_raw;
                    end
                    3'd5: begin
                        w_mul_req.sel     = MSEL_CELL_Y;
                        w_mul_req.operand = r_r1_raw;
                    end
                    3'd6: begin
                        w_mul_req.sel     = MSEL_COLS;
                        w_mul_req.operand = r_r0;
                    end
                    default: begin
                        w_mul_req.sel     = MSEL_RECIP_X;
                        w_mul_req.operand = r_qx;
                    end
                endcase
            end
            default: begin
                w_mul_req.sel     = MSEL_RECIP_X;
                w_mul_req.operand = r_qx;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (i_kind == KIND_QUERY) begin
                        n_state = S_DIV;
                    end else if (i_kind == KIND_WRITE || i_kind == KIND_READ) begin
                        n_state = S_ACC;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ACC:   n_state = S_MEM;
            S_MEM:   n_state = (r_kind == KIND_READ) ? S_RDATA : S_DONE;
            S_RDATA: n_state = S_DONE;
            S_DIV: begin
                if (r_step == 3'd7) begin
                    n_state = w_empty ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                if (w_hit_now) begin
                    n_state = S_DONE;
                end else if (w_last_row && w_last_col) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (w_out_room) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // map port: clearing pass, cell access, or walk read
    always_comb begin
        w_map_we   = 1'b0;
        w_map_re   = 1'b0;
        w_map_wd   = 1'b0;
        w_map_addr = r_addr;
        if (r_clr_busy) begin
            w_map_we   = 1'b1;
            w_map_addr = r_clr_addr;
        end else if (r_state == S_MEM) begin
            w_map_addr = w_cell_addr;
            w_map_we   = (r_kind == KIND_WRITE) && r_inside;
            w_map_re   = (r_kind == KIND_READ);
            w_map_wd   = r_occ;
        end else if (r_state == S_WALK) begin
            w_map_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map[w_map_addr] <= w_map_wd;
        end
        if (w_map_re) begin
            r_map_q <= r_map[w_map_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_grid_w    <= GRID_RESET;
            r_grid_h    <= GRID_RESET;
            r_out_valid <= 1'b0;
            r_chk_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;

            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LP_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                    REG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_DONE && w_out_room) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_DIV) begin
                r_step <= r_step + 3'd1;
            end else begin
                r_step <= '0;
            end

            if (r_state == S_WALK) begin
                r_chk_valid <= 1'b1;
            end else begin
                r_chk_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kind     <= i_kind;
                r_px       <= i_pos_x;
                r_py       <= i_pos_y;
                r_occ      <= i_occupied;
                r_qx       <= CRD_W'(i_pos_x);
                r_qy       <= CRD_W'(i_pos_y);
                r_qr       <= CRD_W'(i_pos_x) + CRD_W'(i_rect_width);
                r_qb       <= CRD_W'(i_pos_y) + CRD_W'(i_rect_height);
                r_res_cell <= 1'b0;
                r_res_hit  <= 1'b0;
            end
            S_ACC: begin
                r_inside <= (CRD_W'(r_px) < w_nc) && (CRD_W'(r_py) < w_nr);
            end
            S_RDATA: begin
                r_res_cell <= r_map_q & r_inside;
            end
            S_DIV: begin
                case (r_step)
                    3'd1: r_c0 <= w_quot;
                    3'd2: begin
                        r_c1_raw <= w_quot;
                        r_c1     <= (w_quot >= w_nc) ? (w_nc - CRD_W'(1)) : w_quot;
                    end
                    3'd3: r_r0 <= w_quot;
                    3'd4: begin
                        r_r1_raw <= w_quot;
                        r_r1     <= (w_quot >= w_nr) ? (w_nr - CRD_W'(1)) : w_quot;
                    end
                    // right or bottom edge exactly on a cell boundary: last column or row only touches
                    3'd5: r_col_bad <= (w_prod == PROD_W'(r_qr)) && (r_c1_raw == r_c1);
                    3'd6: r_row_bad <= (w_prod == PROD_W'(r_qb)) && (r_r1_raw == r_r1);
                    3'd7: begin
                        r_col      <= r_c0;
                        r_row      <= r_r0;
                        r_addr     <= w_prod[AW-1:0] + AW'(r_c0);
                        r_col_base <= w_prod[AW-1:0] + AW'(r_c0);
                    end
                    default: ;
                endcase
            end
            S_WALK: begin
                r_chk_pass <= !(w_last_col && r_col_bad) && !(w_last_row && r_row_bad);
                if (w_hit_now) begin
                    r_res_hit <= 1'b1;
                end
                // column outer, row inner
                if (w_last_row) begin
                    r_row      <= r_r0;
                    r_col      <= r_col + CRD_W'(1);
                    r_addr     <= r_col_base + AW'(1);
                    r_col_base <= r_col_base + AW'(1);
                end else begin
                    r_row  <= r_row + CRD_W'(1);
                    r_addr <= r_addr + LP_ROW_STEP;
                end
            end
            S_DRAIN: begin
                if (w_hit_now) begin
                    r_res_hit <= 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_room) begin
                    r_out_cell <= r_res_cell;
                    r_out_hit  <= r_res_hit;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/tgrc_mul.sv
// Shared multiplier: operand times one of a few elaboration-time constants.
// Depends on tgrc_pkg. Product is registered.
`default_nettype none

module tgrc_mul #(
    parameter int CELL_W   = 16,
    parameter int CELL_H   = 16,
    parameter int MAX_COLS = 64
) (
    input  wire logic                     i_clk,
    input  wire tgrc_pkg::t_mul_req       i_req,
    output logic [tgrc_pkg::PROD_W-1:0]   o_prod
);
    import tgrc_pkg::*;

    localparam logic [RECIP_BITS-1:0] LP_RECIP_X =
        RECIP_BITS'(((2 ** DIV_SHIFT) + CELL_W - 1) / CELL_W);
    localparam logic [RECIP_BITS-1:0] LP_RECIP_Y =
        RECIP_BITS'(((2 ** DIV_SHIFT) + CELL_H - 1) / CELL_H);
    localparam logic [RECIP_BITS-1:0] LP_CELL_X = RECIP_BITS'(CELL_W);
    localparam logic [RECIP_BITS-1:0] LP_CELL_Y = RECIP_BITS'(CELL_H);
    localparam logic [RECIP_BITS-1:0] LP_COLS   = RECIP_BITS'(MAX_COLS);

    logic [RECIP_BITS-1:0] w_k;
    logic [PROD_W-1:0]     r_prod;

    always_comb begin
        case (i_req.sel)
            MSEL_RECIP_X: w_k = LP_RECIP_X;
            MSEL_RECIP_Y: w_k = LP_RECIP_Y;
            MSEL_CELL_X:  w_k = LP_CELL_X;
            MSEL_CELL_Y:  w_k = LP_CELL_Y;
            MSEL_COLS:    w_k = LP_COLS;
            default:      w_k = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.operand) * PROD_W'(w_k);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: rtl/tgrc_chk.sv
// Port-level assertions for the tile grid rectangle collision block, bound to the top.
// Depends on tgrc_pkg for field widths.
`default_nettype none

module tgrc_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_ready,
    input wire logic [tgrc_pkg::KIND_W-1:0]      i_kind,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_ready,
    input wire logic                             o_cell_value,
    input wire logic                             o_hit
);
    import tgrc_pkg::*;

    // one transaction at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a transaction is in flight");

    // a read never reports a hit and a query never reports a cell value
    a_excl_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_cell_value && o_hit))
        else $error("cell value and hit both set");

    // a new result is loaded only from the done state, where input is blocked
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a finished transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before it was taken");

endmodule

bind tile_grid_rect_collision tgrc_chk u_tgrc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_kind       (i_kind),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_cell_value (o_cell_value),
    .o_hit        (o_hit)
);

`default_nettype wire

FILE: tb/tile_grid_rect_collision_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tile grid rectangle collision block: cell writes and
// reads, rectangle queries and grid size registers, with random idling on both sides.
// Depends on tgrc_pkg and the block's RTL; needs nothing else.

module tile_grid_rect_collision_tb;
    import tgrc_pkg::*;

    // Geometry the block is built with; the predictor uses the same values
    localparam int COLS_MAX  = 64;
    localparam int ROWS_MAX  = 64;
    localparam int CELL_PX_W = 16;
    localparam int CELL_PX_H = 16;

    // Kind with no operation behind it
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int MISMATCH_PRINT_MAX = 10;
    localparam int RANDOM_PHASES      = 12;
    localparam int PHASE_ITEMS        = 100;

    // Slowest correct run: ~1200 items, each a full 64x64 walk plus the longest sender
    // gap and receiver stall, plus the clearing pass and the long hold-off: about 100 ms.
    // Taken four times over.
    localparam longint TIMEOUT_NS = 64'd400_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [KIND_W-1:0]    i_kind;
    logic [POS_W-1:0]     i_pos_x;
    logic [POS_W-1:0]     i_pos_y;
    logic                 i_occupied;
    logic [SIZE_W-1:0]    i_rect_width;
    logic [SIZE_W-1:0]    i_rect_height;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_cell_value;
    logic                 o_hit;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [GRID_W-1:0]    i_cfg_data;

    tile_grid_rect_collision #(
        .MAX_COLS(COLS_MAX),
        .MAX_ROWS(ROWS_MAX),
        .CELL_W  (CELL_PX_W),
        .CELL_H  (CELL_PX_H)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_occupied   (i_occupied),
        .i_rect_width (i_rect_width),
        .i_rect_height(i_rect_height),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cell_value (o_cell_value),
        .o_hit        (o_hit),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // One expected result per accepted item, oldest first
    typedef struct packed {
        logic cell_value;
        logic hit;
    } t_outcome;

    t_outcome expected_outcomes[$];
    t_outcome oldest_outcome;

    // Shadow of the occupancy map and of the grid size registers
    bit                tile_map [0:COLS_MAX*ROWS_MAX-1];
    logic [GRID_W-1:0] grid_cols_reg;
    logic [GRID_W-1:0] grid_rows_reg;

    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_hits;
    int unsigned n_mismatch;
    int unsigned n_cfg_writes;
    int unsigned n_settings;

    // Sender / receiver pacing
    bit          idling_on   = 1'b1;
    int unsigned send_gap    = 0;
    bit          in_raised   = 1'b0;
    int unsigned rx_stall    = 0;
    int unsigned rx_hold_req = 0;

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------------------

    // Register values above the map size clamp to it; zero leaves no cell in use
    function automatic int unsigned cols_used();
        return (grid_cols_reg < COLS_MAX) ? grid_cols_reg : COLS_MAX;
    endfunction

    function automatic int unsigned rows_used();
        return (grid_rows_reg < ROWS_MAX) ? grid_rows_reg : ROWS_MAX;
    endfunction

    function automatic bit cell_in_use(int unsigned col, int unsigned row);
        return (col < cols_used()) && (row < rows_used());
    endfunction

    // Walk the cells under the inclusive pixel span, clipped to the grid, and test each
    // occupied one against the half-open rectangle. Touching edges do not overlap.
    function automatic bit rect_hits_map(int unsigned qx, int unsigned qy,
                                         int unsigned qw, int unsigned qh);
        int unsigned right, bottom;
        int unsigned c_first, c_last, r_first, r_last;
        int unsigned left_px, top_px;
        right   = qx + qw;
        bottom  = qy + qh;
        c_first = qx / CELL_PX_W;
        c_last  = right / CELL_PX_W;
        r_first = qy / CELL_PX_H;
        r_last  = bottom / CELL_PX_H;
        if (cols_used() == 0 || rows_used() == 0)
            return 1'b0;
        if (c_last >= cols_used())
            c_last = cols_used() - 1;
        if (r_last >= rows_used())
            r_last = rows_used() - 1;
        for (int unsigned c = c_first; c <= c_last; c++) begin
            for (int unsigned r = r_first; r <= r_last; r++) begin
                if (!tile_map[r*COLS_MAX + c])
                    continue;
                left_px = c * CELL_PX_W;
                top_px  = r * CELL_PX_H;
                if (bottom <= top_px || qy >= top_px + CELL_PX_H)
                    continue;
                if (right <= left_px || qx >= left_px + CELL_PX_W)
                    continue;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Result of one item; a write updates the shadow map
    function automatic t_outcome tile_outcome(logic [KIND_W-1:0] kind,
                                              logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                              logic occ,
                                              logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        t_outcome res;
        res = '0;
        case (kind)
            KIND_WRITE: begin
                if (cell_in_use(x, y))
                    tile_map[int'(y)*COLS_MAX + int'(x)] = occ;
            end
            KIND_READ: begin
                if (cell_in_use(x, y))
                    res.cell_value = tile_map[int'(y)*COLS_MAX + int'(x)];
            end
            KIND_QUERY: begin
                res.hit = rect_hits_map(x, y, w, h);
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------------------------

    // Offer one item and wait for its transaction. The gap before the next item is
    // drawn here so valid is only dropped when a gap really follows.
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic occ,
                             input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        repeat (send_gap) @(posedge i_clk);
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_occupied    <= occ;
        i_rect_width  <= w;
        i_rect_height <= h;
        in_raised = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        expected_outcomes.push_back(tile_outcome(kind, x, y, occ, w, h));
        n_items++;
        send_gap = idling_on ? $urandom_range(0, 5) : 0;
        if (send_gap != 0) begin
            i_in_valid <= 1'b0;
            in_raised = 1'b0;
        end
    endtask

    // Stop offering items and let a clock edge pass so no valid toggles within a step
    task automatic end_items();
        if (in_raised) begin
            i_in_valid <= 1'b0;
            in_raised = 1'b0;
        end
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        end_items();
        while (expected_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GRID_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_GRID_WIDTH)
            grid_cols_reg = val;
        else
            grid_rows_reg = val;
        n_cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers are only touched with nothing in flight; order of the two is random
    task automatic set_grid(input logic [GRID_W-1:0] cols, input logic [GRID_W-1:0] rows);
        wait_drained();
        if ($urandom_range(0, 1)) begin
            write_reg(REG_GRID_WIDTH, cols);
            write_reg(REG_GRID_HEIGHT, rows);
        end else begin
            write_reg(REG_GRID_HEIGHT, rows);
            write_reg(REG_GRID_WIDTH, cols);
        end
        n_settings++;
    endtask

    // Cell index biased toward the top-left 8x8 corner so queries find occupied cells
    function automatic int unsigned pick_index(int unsigned n_used);
        if (n_used == 0)
            return $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 6)
            return $urandom_range(0, ((n_used < 8) ? n_used : 8) - 1);
        return $urandom_range(0, n_used - 1);
    endfunction

    function automatic int unsigned pick_pixel(int unsigned n_used, int unsigned cell_px);
        if ($urandom_range(0, 9) < 6)
            return $urandom_range(0, 140);
        return $urandom_range(0, n_used*cell_px + 20);
    endfunction

    // Mostly in-grid cell traffic and small queries; some cell-aligned queries for
    // touching edges, a little full-range noise and unused kinds.
    task automatic send_random_item();
        int unsigned       pick;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  x, y;
        logic [SIZE_W-1:0] w, h;
        logic              occ;
        pick = $urandom_range(0, 99);
        occ  = ($urandom_range(0, 9) < 6);
        w    = $urandom;
        h    = $urandom;
        if (pick < 60) begin
            kind = (pick < 35) ? KIND_WRITE : KIND_READ;
            if ($urandom_range(0, 9) == 0) begin
                x = $urandom;
                y = $urandom;
            end else begin
                x = pick_index(cols_used());
                y = pick_index(rows_used());
            end
        end else if (pick < 92) begin
            kind = KIND_QUERY;
            if ($urandom_range(0, 9) < 3) begin
                x = pick_index(cols_used()) * CELL_PX_W;
                y = pick_index(rows_used()) * CELL_PX_H;
                w = $urandom_range(0, 2) * CELL_PX_W;
                h = $urandom_range(0, 2) * CELL_PX_H;
            end else begin
                x = pick_pixel(cols_used(), CELL_PX_W);
                y = pick_pixel(rows_used(), CELL_PX_H);
                w = $urandom_range(0, 48);
                h = $urandom_range(0, 48);
            end
        end else if (pick < 97) begin
            kind = $urandom_range(0, 3);
            x    = $urandom;
            y    = $urandom;
        end else begin
            kind = KIND_SPARE;
            x    = $urandom;
            y    = $urandom;
        end
        send_item(kind, x, y, occ, w, h);
    endtask

    // ---------------------------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------------------------

    // Receiver pacing: a random stall after each transaction, or a long hold-off when a
    // test asks for one.
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_stall    = rx_hold_req;
            rx_hold_req = 0;
        end else if (o_out_valid && i_out_ready) begin
            rx_stall = idling_on ? $urandom_range(0, 5) : 0;
        end else if (rx_stall != 0) begin
            rx_stall--;
        end
        i_out_ready <= (rx_stall == 0);
    end

    // Compare every result transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_outcomes.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MISMATCH_PRINT_MAX)
                    $display("[%0t] result with nothing expected: cell_value %0b hit %0b",
                             $realtime, o_cell_value, o_hit);
            end else begin
                oldest_outcome = expected_outcomes.pop_front();
                if (oldest_outcome.hit)
                    n_hits++;
                if (o_cell_value !== oldest_outcome.cell_value ||
                    o_hit !== oldest_outcome.hit) begin
                    n_mismatch++;
                    if (n_mismatch <= MISMATCH_PRINT_MAX)
                        $display("[%0t] result %0d: cell_value exp %0b got %0b, hit exp %0b got %0b",
                                 $realtime, n_results, oldest_outcome.cell_value,
                                 o_cell_value, oldest_outcome.hit, o_hit);
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    // Corner cells, cells past the grid, the all-ones item of the unused kind
    task automatic test_cell_access();
        send_item(KIND_WRITE, 12'd0, 12'd0, 1'b1, 12'd0, 12'd0);
        send_item(KIND_WRITE, 12'd63, 12'd63, 1'b1, 12'hFFF, 12'hFFF);
        send_item(KIND_READ, 12'd0, 12'd0, 1'b0, 12'd0, 12'd0);
        send_item(KIND_READ, 12'd63, 12'd63, 1'b1, 12'hFFF, 12'hFFF);
        send_item(KIND_WRITE, 12'd64, 12'd0, 1'b1, 12'd0, 12'd0);
        send_item(KIND_READ, 12'd64, 12'd0, 1'b0, 12'd0, 12'd0);
        send_item(KIND_WRITE, 12'hFFF, 12'hFFF, 1'b1, 12'd0, 12'd0);
        send_item(KIND_READ, 12'hFFF, 12'hFFF, 1'b0, 12'd0, 12'd0);
        send_item(KIND_SPARE, 12'hFFF, 12'hFFF, 1'b1, 12'hFFF, 12'hFFF);
    endtask

    // Cells (0,0) and (63,63) are occupied here
    task automatic test_query_edges();
        // right neighbor of (0,0), left edge only touching
        send_item(KIND_QUERY, 12'd16, 12'd0, 1'b0, 12'd16, 12'd16);
        // zero-size rectangle strictly inside an occupied cell
        send_item(KIND_QUERY, 12'd8, 12'd8, 1'b0, 12'd0, 12'd0);
        // whole grid
        send_item(KIND_QUERY, 12'd0, 12'd0, 1'b0, 12'hFFF, 12'hFFF);
        send_item(KIND_QUERY, 12'd1000, 12'd1000, 1'b0, 12'd10, 12'd10);
        // zero-size rectangle on the corner of (63,63)
        send_item(KIND_QUERY, 12'd1008, 12'd1008, 1'b1, 12'd0, 12'd0);
        // starts past the grid
        send_item(KIND_QUERY, 12'hFFF, 12'hFFF, 1'b0, 12'hFFF, 12'hFFF);
        // zero-width strip down the last column
        send_item(KIND_QUERY, 12'd1016, 12'd0, 1'b0, 12'd0, 12'hFFF);
    endtask

    // Smallest, empty, oversized and odd grids; stored bits survive a shrink
    task automatic test_grid_limits();
        set_grid(7'd1, 7'd1);
        send_item(KIND_READ, 12'd0, 12'd0, 1'b0, 12'd0, 12'd0);
        send_item(KIND_READ, 12'd63, 12'd63, 1'b0, 12'd0, 12'd0);
        send_item(KIND_QUERY, 12'd0, 12'd0, 1'b0, 12'hFFF, 12'hFFF);
        set_grid(7'd0, 7'd1);
        send_item(KIND_READ, 12'd0, 12'd0, 1'b0, 12'd0, 12'd0);
        send_item(KIND_QUERY, 12'd0, 12'd0, 1'b0, 12'hFFF, 12'hFFF);
        set_grid(7'd127, 7'd127);
        send_item(KIND_READ, 12'd63, 12'd63, 1'b0, 12'd0, 12'd0);
        set_grid(7'd65, 7'd3);
        send_item(KIND_WRITE, 12'd63, 12'd2, 1'b1, 12'd0, 12'd0);
        send_item(KIND_READ, 12'd63, 12'd2, 1'b0, 12'd0, 12'd0);
        send_item(KIND_READ, 12'd63, 12'd3, 1'b0, 12'd0, 12'd0);
    endtask

    // Several grid settings; idling is switched off for every fourth phase
    task automatic test_random_phases();
        logic [GRID_W-1:0] cols_tab [0:9];
        logic [GRID_W-1:0] rows_tab [0:9];
        cols_tab = '{7'd64, 7'd5, 7'd1, 7'd64, 7'd1, 7'd127, 7'd0, 7'd65, 7'd17, 7'd64};
        rows_tab = '{7'd64, 7'd4, 7'd1, 7'd1, 7'd64, 7'd127, 7'd12, 7'd0, 7'd64, 7'd33};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 10)
                set_grid(cols_tab[p], rows_tab[p]);
            else
                set_grid($urandom_range(0, 127), $urandom_range(0, 127));
            idling_on = (p % 4 != 3);
            repeat (PHASE_ITEMS) send_random_item();
        end
        idling_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while items keep coming, so the result
    // register and the done state both fill and the input stalls.
    task automatic test_output_hold();
        set_grid(7'd64, 7'd64);
        idling_on   = 1'b0;
        rx_hold_req = 300;
        repeat (16) send_random_item();
        idling_on = 1'b1;
    endtask

    // Sender stops until everything in flight has come back, then resumes
    task automatic test_drain_pause();
        repeat (10) send_random_item();
        wait_drained();
        repeat (10) send_random_item();
    endtask

    // ---------------------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------------------

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_WRITE;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_occupied    = 1'b0;
        i_rect_width  = '0;
        i_rect_height = '0;
        i_out_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_GRID_WIDTH;
        i_cfg_data    = '0;
        for (int i = 0; i < COLS_MAX*ROWS_MAX; i++)
            tile_map[i] = 1'b0;
        grid_cols_reg = GRID_RESET;
        grid_rows_reg = GRID_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the first item waits out the clearing pass on o_in_ready
        test_cell_access();
        test_query_edges();
        test_grid_limits();
        test_random_phases();
        test_output_hold();
        test_drain_pause();

        wait_drained();
        repeat (30) @(posedge i_clk);

        $display("Sent %0d items (%0d expected hits) and made %0d register writes over %0d grid settings;",
                 n_items, n_hits, n_cfg_writes, n_settings);
        $display("checked %0d results, %0d mismatched, %0d still outstanding.",
                 n_results, n_mismatch, expected_outcomes.size());
        if (n_mismatch == 0 && expected_outcomes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", expected_outcomes.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
